>>> hdl/cau_pkg.sv
// Package for the complex arithmetic unit: widths, opcodes, status codes and the
// command, result and pipeline structs. It has no dependencies.
`timescale 1ns / 1ps

package cau_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int TolWidth  = 16;
  localparam int ProdW     = 2 * DataWidth;
  localparam int SumW      = ProdW + 1;
  localparam int NumW      = SumW + FracBits;
  localparam int DenW      = SumW;

  typedef enum logic [2:0] {
    OpAdd       = 3'd0,
    OpSub       = 3'd1,
    OpMul       = 3'd2,
    OpDiv       = 3'd3,
    OpDivScalar = 3'd4,
    OpConj      = 3'd5,
    OpModSq     = 3'd6,
    OpEqual     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusDivZero  = 2'd1,
    StatusOverflow = 2'd2
  } status_e;

  typedef struct packed {
    op_e                          op;
    logic signed [DataWidth-1:0]  a_real;
    logic signed [DataWidth-1:0]  a_imag;
    logic signed [DataWidth-1:0]  b_real;
    logic signed [DataWidth-1:0]  b_imag;
    logic signed [DataWidth-1:0]  divisor_scalar;
  } cau_in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0]  res_real;
    logic signed [DataWidth-1:0]  res_imag;
    logic                         is_equal;
    status_e                      status;
  } cau_out_t;

  typedef struct packed {
    op_e                          op;
    logic signed [DataWidth-1:0]  ar;
    logic signed [DataWidth-1:0]  ai;
    logic signed [DataWidth-1:0]  ds;
    logic signed [ProdW-1:0]      rr;
    logic signed [ProdW-1:0]      ii;
    logic signed [ProdW-1:0]      ri;
    logic signed [ProdW-1:0]      ir;
    logic signed [ProdW-1:0]      aa;
    logic signed [ProdW-1:0]      a2;
    logic signed [ProdW-1:0]      bb;
    logic signed [ProdW-1:0]      b2;
    logic signed [SumW-1:0]       pass_r;
    logic signed [SumW-1:0]       pass_i;
    logic                         eq;
  } prod_t;

  typedef struct packed {
    logic                         is_div;
    logic                         dz;
    logic                         neg_r;
    logic                         neg_i;
    logic [DenW-1:0]              den;
    logic signed [SumW-1:0]       pass_r;
    logic signed [SumW-1:0]       pass_i;
    logic                         eq;
  } ctrl_t;

  typedef struct packed {
    logic [NumW-1:0]              nq;
    logic [DenW-1:0]              rem;
  } lane_t;

endpackage

>>> hdl/cau_product.sv
// Product stage: registers all operand products, the add, subtract and conjugate
// sums and the tolerance compare. Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_product (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  cau_pkg::cau_in_t  cmd_i,
  input  logic [cau_pkg::TolWidth-1:0] tol_i,
  output logic              valid_o,
  output cau_pkg::prod_t    prod_o
);
  import cau_pkg::*;

  function automatic logic signed [SumW-1:0] ext(input logic signed [DataWidth-1:0] x);
    ext = {{(SumW - DataWidth){x[DataWidth-1]}}, x};
  endfunction

  function automatic logic in_tolerance(input logic signed [SumW-1:0] d,
                                        input logic [TolWidth-1:0] t);
    logic [SumW-1:0] mag;
    mag = d[SumW-1] ? (~d + 1'b1) : d;
    in_tolerance = mag <= {{(SumW - TolWidth){1'b0}}, t};
  endfunction

  logic   valid_q;
  prod_t  prod_d, prod_q;

  always_comb begin
    prod_d    = '0;
    prod_d.op = cmd_i.op;
    prod_d.ar = cmd_i.a_real;
    prod_d.ai = cmd_i.a_imag;
    prod_d.ds = cmd_i.divisor_scalar;
    prod_d.rr = cmd_i.a_real * cmd_i.b_real;
    prod_d.ii = cmd_i.a_imag * cmd_i.b_imag;
    prod_d.ri = cmd_i.a_real * cmd_i.b_imag;
    prod_d.ir = cmd_i.a_imag * cmd_i.b_real;
    prod_d.aa = cmd_i.a_real * cmd_i.a_real;
    prod_d.a2 = cmd_i.a_imag * cmd_i.a_imag;
    prod_d.bb = cmd_i.b_real * cmd_i.b_real;
    prod_d.b2 = cmd_i.b_imag * cmd_i.b_imag;
    case (cmd_i.op)
      OpAdd: begin
        prod_d.pass_r = ext(cmd_i.a_real) + ext(cmd_i.b_real);
        prod_d.pass_i = ext(cmd_i.a_imag) + ext(cmd_i.b_imag);
      end
      OpSub: begin
        prod_d.pass_r = ext(cmd_i.a_real) - ext(cmd_i.b_real);
        prod_d.pass_i = ext(cmd_i.a_imag) - ext(cmd_i.b_imag);
      end
      OpConj: begin
        prod_d.pass_r = ext(cmd_i.a_real);
        prod_d.pass_i = -ext(cmd_i.a_imag);
      end
      OpEqual: begin
        prod_d.eq = in_tolerance(ext(cmd_i.a_real) - ext(cmd_i.b_real), tol_i) &&
                    in_tolerance(ext(cmd_i.a_imag) - ext(cmd_i.b_imag), tol_i);
      end
      default: begin
        prod_d.pass_r = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

>>> hdl/cau_div_step.sv
// One registered step of the pipelined restoring divider, two lanes sharing one
// divisor. Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_div_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  cau_pkg::ctrl_t  ctrl_i,
  input  cau_pkg::lane_t  lane_r_i,
  input  cau_pkg::lane_t  lane_i_i,
  output logic            valid_o,
  output cau_pkg::ctrl_t  ctrl_o,
  output cau_pkg::lane_t  lane_r_o,
  output cau_pkg::lane_t  lane_i_o
);
  import cau_pkg::*;

  function automatic lane_t step(input lane_t l, input logic [DenW-1:0] d);
    logic [DenW:0] trial;
    logic [DenW:0] diff;
    logic          ge;
    trial   = {l.rem, l.nq[NumW-1]};
    diff    = trial - {1'b0, d};
    ge      = trial >= {1'b0, d};
    step.rem = ge ? diff[DenW-1:0] : trial[DenW-1:0];
    step.nq  = {l.nq[NumW-2:0], ge};
  endfunction

  logic   valid_q;
  ctrl_t  ctrl_q;
  lane_t  lane_r_q, lane_i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl_q   <= ctrl_i;
    lane_r_q <= step(lane_r_i, ctrl_i.den);
    lane_i_q <= step(lane_i_i, ctrl_i.den);
  end

  assign valid_o  = valid_q;
  assign ctrl_o   = ctrl_q;
  assign lane_r_o = lane_r_q;
  assign lane_i_o = lane_i_q;

endmodule

>>> hdl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: input register, product stage,
// combine stage, divider chain and saturating output. Depends on cau_pkg,
// cau_product and cau_div_step.
//
//   channel  | ports                          | transfer
//   ---------+--------------------------------+------------------------------
//   command  | start, busy, cmd_i             | start high and busy low
//   result   | res_valid_o, res_o             | res_valid_o high
//   config   | cfg_valid_i, cfg_ready_o, cfg_data_i | valid and ready high
//
// The pipeline depth is set by the divider chain of one quotient bit per stage;
// a new command is taken every cycle.
// Every operation runs through the same pipeline, so results leave in order.
// busy is always low and the result side has no stall.
// Reset clears the valid bits and sets the tolerance to one.
`timescale 1ns / 1ps

module complex_arithmetic_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  cau_pkg::cau_in_t              cmd_i,
  output logic                          res_valid_o,
  output cau_pkg::cau_out_t             res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cau_pkg::TolWidth-1:0]  cfg_data_i
);
  import cau_pkg::*;

  function automatic logic signed [SumW-1:0] ext_p(input logic signed [ProdW-1:0] x);
    ext_p = {x[ProdW-1], x};
  endfunction

  function automatic logic [NumW-1:0] mag_n(input logic [NumW-1:0] x);
    mag_n = x[NumW-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [DataWidth-1:0] sat(input logic signed [NumW:0] v,
                                               output logic ov);
    logic [NumW-DataWidth+1:0] top;
    top = v[NumW:DataWidth-1];
    ov  = !((&top) || !(|top));
    if (!ov) begin
      sat = v[DataWidth-1:0];
    end else if (v[NumW]) begin
      sat = {1'b1, {(DataWidth-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DataWidth-1){1'b1}}};
    end
  endfunction

  logic [TolWidth-1:0] tol_q;
  logic                in_valid_q;
  cau_in_t             in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q      <= {{(TolWidth-1){1'b0}}, 1'b1};
      in_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        tol_q <= cfg_data_i;
      end
      in_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= cmd_i;
  end

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic   prod_valid;
  prod_t  prod;

  cau_product u_product (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .cmd_i   (in_q),
    .tol_i   (tol_q),
    .valid_o (prod_valid),
    .prod_o  (prod)
  );

  logic                   valid_c [0:NumW];
  ctrl_t                  ctrl_c  [0:NumW];
  lane_t                  lr_c    [0:NumW];
  lane_t                  li_c    [0:NumW];

  ctrl_t                  comb_ctrl;
  logic [NumW-1:0]        num_r, num_i;
  logic signed [DenW-1:0] den_s;
  logic signed [SumW-1:0] mul_r, mul_i, mod_s, dnr, dni, msq;

  always_comb begin
    mul_r = ext_p(prod.rr) - ext_p(prod.ii);
    mul_i = ext_p(prod.ri) + ext_p(prod.ir);
    dnr   = ext_p(prod.rr) + ext_p(prod.ii);
    dni   = ext_p(prod.ir) - ext_p(prod.ri);
    mod_s = ext_p(prod.aa) + ext_p(prod.a2);
    msq   = ext_p(prod.bb) + ext_p(prod.b2);
    comb_ctrl        = '0;
    comb_ctrl.pass_r = prod.pass_r;
    comb_ctrl.pass_i = prod.pass_i;
    comb_ctrl.eq     = prod.eq;
    num_r = '0;
    num_i = '0;
    den_s = '0;
    case (prod.op)
      OpMul: begin
        comb_ctrl.pass_r = mul_r >>> FracBits;
        comb_ctrl.pass_i = mul_i >>> FracBits;
      end
      OpModSq: begin
        comb_ctrl.pass_r = mod_s >>> FracBits;
        comb_ctrl.pass_i = '0;
      end
      OpDiv: begin
        comb_ctrl.is_div = 1'b1;
        comb_ctrl.dz     = msq == '0;
        num_r = {dnr, {FracBits{1'b0}}};
        num_i = {dni, {FracBits{1'b0}}};
        den_s = msq;
      end
      OpDivScalar: begin
        comb_ctrl.is_div = 1'b1;
        comb_ctrl.dz     = prod.ds == '0;
        num_r = {{(SumW-DataWidth){prod.ar[DataWidth-1]}}, prod.ar, {FracBits{1'b0}}};
        num_i = {{(SumW-DataWidth){prod.ai[DataWidth-1]}}, prod.ai, {FracBits{1'b0}}};
        den_s = {{(DenW-DataWidth){prod.ds[DataWidth-1]}}, prod.ds};
      end
      default: begin
        comb_ctrl.is_div = 1'b0;
      end
    endcase
    comb_ctrl.neg_r = num_r[NumW-1] ^ den_s[DenW-1];
    comb_ctrl.neg_i = num_i[NumW-1] ^ den_s[DenW-1];
    comb_ctrl.den   = den_s[DenW-1] ? (~den_s + 1'b1) : den_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c[0] <= 1'b0;
    end else begin
      valid_c[0] <= prod_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl_c[0] <= comb_ctrl;
    lr_c[0]   <= '{nq: mag_n(num_r), rem: '0};
    li_c[0]   <= '{nq: mag_n(num_i), rem: '0};
  end

  for (genvar k = 0; k < NumW; k++) begin : g_div
    cau_div_step u_step (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (valid_c[k]),
      .ctrl_i   (ctrl_c[k]),
      .lane_r_i (lr_c[k]),
      .lane_i_i (li_c[k]),
      .valid_o  (valid_c[k+1]),
      .ctrl_o   (ctrl_c[k+1]),
      .lane_r_o (lr_c[k+1]),
      .lane_i_o (li_c[k+1])
    );
  end

  ctrl_t              fin;
  logic signed [NumW:0] val_r, val_i;
  logic               ov_r, ov_i;
  cau_out_t           res_d, res_q;
  logic               res_valid_q;

  always_comb begin
    fin = ctrl_c[NumW];
    if (fin.is_div) begin
      val_r = fin.neg_r ? -{1'b0, lr_c[NumW].nq} : {1'b0, lr_c[NumW].nq};
      val_i = fin.neg_i ? -{1'b0, li_c[NumW].nq} : {1'b0, li_c[NumW].nq};
    end else begin
      val_r = {{(NumW+1-SumW){fin.pass_r[SumW-1]}}, fin.pass_r};
      val_i = {{(NumW+1-SumW){fin.pass_i[SumW-1]}}, fin.pass_i};
    end
    res_d.res_real = sat(val_r, ov_r);
    res_d.res_imag = sat(val_i, ov_i);
    res_d.is_equal = fin.eq;
    if (fin.is_div && fin.dz) begin
      res_d.res_real = '0;
      res_d.res_imag = '0;
      res_d.status   = StatusDivZero;
    end else if (ov_r || ov_i) begin
      res_d.status = StatusOverflow;
    end else begin
      res_d.status = StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= valid_c[NumW];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
